### rtl/rilbp_pkg.sv
package rilbp_pkg;

  // Fixed field widths
  localparam int unsigned CODE_BITS       = 8;
  localparam int unsigned NEIGHBOURS      = 8;
  localparam int unsigned WIDTH_REG_BITS  = 8;
  localparam int unsigned HEIGHT_REG_BITS = 12;
  localparam int unsigned CFG_DATA_BITS   = 12;
  localparam int unsigned CFG_IDX_BITS    = 1;

  // Smallest usable image dimension
  localparam int unsigned MIN_DIM = 3;

  // Configuration register indices
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Register values after reset
  localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_WIDTH_RST  = 8'd128;
  localparam logic [HEIGHT_REG_BITS-1:0] IMAGE_HEIGHT_RST = 12'd4095;

  // One result item
  typedef struct packed {
    logic [CODE_BITS-1:0] lbp_code;
    logic                 row_end;
    logic                 frame_end;
  } code_t;

endpackage

### rtl/rilbp_ifs.sv
// Pixel stream channel
interface rilbp_pix_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Code stream channel
interface rilbp_code_if;
  logic                               valid;
  logic                               ready;
  logic [rilbp_pkg::CODE_BITS-1:0]    lbp_code;
  logic                               row_end;
  logic                               frame_end;

  modport source (output valid, output lbp_code, output row_end, output frame_end, input ready);
  modport sink   (input valid, input lbp_code, input row_end, input frame_end, output ready);
endinterface

### rtl/rilbp_line_buf.sv
// Two-row line store: one word per column holds {row above, current row}.
// One read and one write port, read data registered.
module rilbp_line_buf #(
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned DATA_BITS = 16,
  parameter int unsigned AW        = 7
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [DATA_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [DATA_BITS-1:0] wr_data_i
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/rotation_invariant_lbp_3x3.sv
// Output path: the pixel completing a window is held in the stage 1 register, then its
//   code is written to the output register.
// Throughput: one pixel per cycle unless stalled; the line store read at the column counter
//   and the window/compare stage both take a new pixel each cycle. A stalled sink holding a
//   code keeps its successor in stage 1, and input ready follows the sink's ready in that cycle.
// Reset (rst_ni, asynchronous, active low): counters, window and valids cleared, registers
//   return to width 128 / height 4095; the line store is not cleared.
module rotation_invariant_lbp_3x3 #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rilbp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [rilbp_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  rilbp_pix_if.sink                             pix_i,
  rilbp_code_if.source                          code_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (CW + 1 > rilbp_pkg::WIDTH_REG_BITS) ? CW + 1
                                                                    : rilbp_pkg::WIDTH_REG_BITS;
  localparam int unsigned HB = rilbp_pkg::HEIGHT_REG_BITS;
  localparam int unsigned CB = rilbp_pkg::CODE_BITS;

  // smallest circular rotation of the comparison pattern
  function automatic logic [CB-1:0] min_rot(input logic [CB-1:0] p);
    logic [CB-1:0] best;
    logic [CB-1:0] rot;
    best = p;
    for (int i = 1; i < CB; i++) begin
      rot = (p >> i) | (p << (CB - i));
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

  // configuration registers
  logic [rilbp_pkg::WIDTH_REG_BITS-1:0] width_q;
  logic [HB-1:0]                        height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rilbp_pkg::IMAGE_WIDTH_RST;
      height_q <= rilbp_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (rilbp_pkg::cfg_reg_e'(cfg_idx_i))
        rilbp_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[rilbp_pkg::WIDTH_REG_BITS-1:0];
        end
        rilbp_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[HB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective dimensions after clamping
  logic [WW-1:0] w_raw, w_eff, col_ext, col_eff;
  logic [HB-1:0] h_eff;
  logic [CW-1:0] col_q, col_d;
  logic [HB-1:0] row_q, row_d;
  logic          last_col, last_row, code_here;

  always_comb begin
    w_raw = WW'(width_q);
    if (w_raw < WW'(rilbp_pkg::MIN_DIM)) begin
      w_eff = WW'(rilbp_pkg::MIN_DIM);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (height_q < HB'(rilbp_pkg::MIN_DIM)) ? HB'(rilbp_pkg::MIN_DIM) : height_q;

    col_ext   = WW'(col_q);
    col_eff   = (col_ext >= w_eff) ? w_eff - WW'(1) : col_ext;
    last_col  = (col_eff >= w_eff - WW'(1));
    last_row  = (row_q >= h_eff - HB'(1));
    code_here = (row_q >= HB'(2)) && (col_eff >= WW'(2));
  end

  // handshake and stage control
  logic s1_valid_q, s1_code_q, s1_row_end_q, s1_frame_end_q;
  logic out_valid_q;
  logic s1_adv, in_xfer;

  assign s1_adv      = s1_valid_q && (!s1_code_q || !out_valid_q || code_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer     = pix_i.valid && pix_i.ready;

  // raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HB'(1);
      end else begin
        col_d = CW'(col_eff + WW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: pixel, column and flags alongside the line store read
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [CW-1:0]         s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s1_code_q      <= 1'b0;
      s1_row_end_q   <= 1'b0;
      s1_frame_end_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q     <= 1'b1;
      s1_code_q      <= code_here;
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q <= pix_i.pixel;
      s1_col_q <= CW'(col_eff);
    end
  end

  // line store: read at transfer, written back as the item leaves stage 1
  logic [2*PIXEL_BITS-1:0] lb_rd_data;
  logic [PIXEL_BITS-1:0]   top, mid;

  assign top = lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid = lb_rd_data[PIXEL_BITS-1:0];

  rilbp_line_buf #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * PIXEL_BITS),
    .AW        (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (CW'(col_eff)),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, s1_pix_q})
  );

  // 3x3 window: two previous columns, rows top / middle / bottom
  logic [PIXEL_BITS-1:0] win_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      win_q[0][0] <= win_q[1][0];
      win_q[0][1] <= win_q[1][1];
      win_q[0][2] <= win_q[1][2];
      win_q[1][0] <= top;
      win_q[1][1] <= mid;
      win_q[1][2] <= s1_pix_q;
    end
  end

  // neighbour compare, bit i for neighbour i starting at left, going anticlockwise
  localparam int unsigned NB_CNT = rilbp_pkg::NEIGHBOURS;
  logic [PIXEL_BITS-1:0] nb [NB_CNT];
  logic [CB-1:0]         pattern;
  logic [PIXEL_BITS-1:0] centre;

  assign centre = win_q[1][1];
  assign nb[0]  = win_q[0][1];
  assign nb[1]  = win_q[0][2];
  assign nb[2]  = win_q[1][2];
  assign nb[3]  = s1_pix_q;
  assign nb[4]  = mid;
  assign nb[5]  = top;
  assign nb[6]  = win_q[1][0];
  assign nb[7]  = win_q[0][0];

  always_comb begin
    for (int i = 0; i < NB_CNT; i++) begin
      pattern[i] = (nb[i] >= centre);
    end
  end

  // output register
  rilbp_pkg::code_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_code_q) begin
      out_valid_q <= 1'b1;
    end else if (code_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_code_q) begin
      out_q.lbp_code  <= min_rot(pattern);
      out_q.row_end   <= s1_row_end_q;
      out_q.frame_end <= s1_frame_end_q;
    end
  end

  assign code_o.valid     = out_valid_q;
  assign code_o.lbp_code  = out_q.lbp_code;
  assign code_o.row_end   = out_q.row_end;
  assign code_o.frame_end = out_q.frame_end;

  // checks
  a_frame_end_is_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.row_end)
    else $error("frame end flagged without row end");

  a_code_is_min_rotation : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.lbp_code <= {out_q.lbp_code[0], out_q.lbp_code[CB-1:1]})
    else $error("code is not the smallest rotation");

  a_no_same_column_rw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s1_adv |-> s1_col_q != CW'(col_eff))
    else $error("line store read and write collide on one column");

  a_frame_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_col && last_row |=> row_q == '0 && col_q == '0)
    else $error("counters did not restart after the last pixel of a frame");

endmodule

### dv/tb_rotation_invariant_lbp_3x3.sv
`timescale 1ns / 100ps

module tb_rotation_invariant_lbp_3x3;

  localparam int unsigned LINE_MAX    = 128;
  localparam int unsigned PIX_BITS    = 8;
  // cycles allowed for the pipeline to empty once nothing is expected
  localparam int unsigned DRAIN_CYCLES = 6;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we;
  rilbp_pkg::cfg_reg_e                 cfg_idx;
  logic [rilbp_pkg::CFG_DATA_BITS-1:0] cfg_data;

  rilbp_pix_if #(.PIXEL_BITS(PIX_BITS)) pix_if ();
  rilbp_code_if                         code_if ();

  rotation_invariant_lbp_3x3 #(
    .MAX_WIDTH  (LINE_MAX),
    .PIXEL_BITS (PIX_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .code_o     (code_if)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idling controls, percent of cycles
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned fail_count;
  int unsigned pixels_sent;

  // Shadow of the block: registers, line store, column window, counters
  logic [rilbp_pkg::WIDTH_REG_BITS-1:0]  width_reg;
  logic [rilbp_pkg::HEIGHT_REG_BITS-1:0] height_reg;
  logic [PIX_BITS-1:0]        line_rows [2][LINE_MAX];
  logic [PIX_BITS-1:0]        win_cols  [2][3];  // [0] = column c-2, [1] = column c-1
  int unsigned                row_idx;
  int unsigned                col_idx;

  rilbp_pkg::code_t expected_codes [$];

  // Smallest of the eight circular rotations
  function automatic logic [rilbp_pkg::CODE_BITS-1:0] smallest_rotation(
    input logic [rilbp_pkg::CODE_BITS-1:0] p);
    logic [rilbp_pkg::CODE_BITS-1:0] best;
    logic [rilbp_pkg::CODE_BITS-1:0] rot;
    best = '1;
    rot  = p;
    for (int i = 0; i < rilbp_pkg::NEIGHBOURS; i++) begin
      if (rot < best) best = rot;
      rot = {rot[0], rot[rilbp_pkg::CODE_BITS-1:1]};
    end
    return best;
  endfunction

  // Advance the shadow by one accepted pixel; queue the code it completes, if any
  function automatic void predict_pixel(input logic [PIX_BITS-1:0] px);
    int unsigned                     w;
    int unsigned                     h;
    int unsigned                     c;
    int unsigned                     r;
    logic [PIX_BITS-1:0]             top;
    logic [PIX_BITS-1:0]             mid;
    logic [PIX_BITS-1:0]             ctr;
    logic [PIX_BITS-1:0]             nb [rilbp_pkg::NEIGHBOURS];
    logic [rilbp_pkg::CODE_BITS-1:0] pattern;
    logic                            last_col;
    logic                            last_row;
    rilbp_pkg::code_t                want;
    w = width_reg;
    if (w < rilbp_pkg::MIN_DIM) w = rilbp_pkg::MIN_DIM;
    if (w > LINE_MAX) w = LINE_MAX;
    h = height_reg;
    if (h < rilbp_pkg::MIN_DIM) h = rilbp_pkg::MIN_DIM;
    c = col_idx;
    r = row_idx;
    // a shrunk width clamps the column and ends the row
    if (c >= w) c = w - 1;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);

    top = line_rows[0][c];
    mid = line_rows[1][c];
    line_rows[0][c] = mid;
    line_rows[1][c] = px;

    if (r >= 2 && c >= 2) begin
      ctr = win_cols[1][1];
      // left, below-left, below, below-right, right, above-right, above, above-left
      nb = '{win_cols[0][1], win_cols[0][2], win_cols[1][2], px,
             mid, top, win_cols[1][0], win_cols[0][0]};
      for (int i = 0; i < rilbp_pkg::NEIGHBOURS; i++) pattern[i] = (nb[i] >= ctr);
      want.lbp_code  = smallest_rotation(pattern);
      want.row_end   = last_col;
      want.frame_end = last_col && last_row;
      expected_codes.push_back(want);
    end

    win_cols[0] = win_cols[1];
    win_cols[1] = '{top, mid, px};

    if (last_col) begin
      col_idx = 0;
      row_idx = last_row ? 0 : ((r + 1) & 12'hFFF);
    end else begin
      col_idx = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Code sink: random back-pressure and field-by-field comparison
  always @(posedge clk_i) begin : code_check
    rilbp_pkg::code_t want;
    code_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_ni && code_if.valid && code_if.ready) begin
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code %02h row_end %0b frame_end %0b",
                                  code_if.lbp_code, code_if.row_end, code_if.frame_end));
      end else begin
        want = expected_codes.pop_front();
        if (code_if.lbp_code !== want.lbp_code)
          report_mismatch($sformatf("lbp_code %02h, expected %02h",
                                    code_if.lbp_code, want.lbp_code));
        if (code_if.row_end !== want.row_end)
          report_mismatch($sformatf("row_end %0b, expected %0b (code %02h)",
                                    code_if.row_end, want.row_end, want.lbp_code));
        if (code_if.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %0b, expected %0b (code %02h)",
                                    code_if.frame_end, want.frame_end, want.lbp_code));
      end
    end
  end

  // One pixel transfer, with optional idle cycles ahead of it
  task automatic send_pixel(input logic [PIX_BITS-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    predict_pixel(value);
    pixels_sent++;
  endtask

  // Drop valid, let every expected code arrive, then let the pipeline drain
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rilbp_pkg::cfg_reg_e idx,
                           input logic [rilbp_pkg::CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      rilbp_pkg::REG_IMAGE_WIDTH:  width_reg  = data[rilbp_pkg::WIDTH_REG_BITS-1:0];
      rilbp_pkg::REG_IMAGE_HEIGHT: height_reg = data[rilbp_pkg::HEIGHT_REG_BITS-1:0];
      default: ;
    endcase
  endtask

  // Values biased towards the extremes and towards near-equal neighbours
  function automatic logic [PIX_BITS-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PIX_BITS'($urandom_range(100, 103));
      default: return PIX_BITS'($urandom_range(255));
    endcase
  endfunction

  // Send pixels until the counters are back at the start of a frame
  task automatic finish_frame();
    while (row_idx != 0 || col_idx != 0) send_pixel(random_pixel());
  endtask

  task automatic send_frame();
    do send_pixel(random_pixel()); while (row_idx != 0 || col_idx != 0);
  endtask

  // Reset geometry (128 wide, 4095 high), then the height cut mid-frame
  task automatic test_default_geometry();
    repeat (3 * LINE_MAX) send_pixel(random_pixel());
    // row 3 is already past the new last row: the frame ends with this row
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h000);
    finish_frame();
  endtask

  // Hand-picked 3-wide frame: flat areas, 0/255 extremes, equal and one-off neighbours
  task automatic test_code_patterns();
    logic [PIX_BITS-1:0] rows [24];
    rows = '{8'd7,   8'd7,   8'd7,
             8'd7,   8'd7,   8'd7,
             8'd0,   8'd255, 8'd0,
             8'd255, 8'd0,   8'd255,
             8'd0,   8'd1,   8'd0,
             8'd254, 8'd255, 8'd254,
             8'd0,   8'd0,   8'd0,
             8'd255, 8'd255, 8'd255};
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h003);
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h008);
    foreach (rows[i]) send_pixel(rows[i]);
  endtask

  // Out-of-range and extreme register values
  task automatic test_register_extremes();
    // width byte 0 with upper data bits set, height below minimum
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'hF00);
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h001);
    repeat (9) send_pixel(random_pixel());
    // width above the line length
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h0FF);
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h002);
    send_frame();
    // tallest frame, cut short by a height write mid-frame
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h001);
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
    repeat (18) send_pixel(random_pixel());
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h003);
    finish_frame();
  endtask

  // Width shrunk below the current column, then grown, both mid-frame
  task automatic test_mid_row_resize();
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h00A);
    write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 12'h005);
    repeat (27) send_pixel(random_pixel());
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h004);
    repeat (6) send_pixel(random_pixel());
    // every line-store entry has been written by now
    write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 12'h00C);
    finish_frame();
  endtask

  // Random narrow geometries and content under one idling mode
  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned n_pixels);
    int unsigned start;
    logic [rilbp_pkg::CFG_DATA_BITS-1:0] w_raw;
    logic [rilbp_pkg::CFG_DATA_BITS-1:0] h_raw;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) begin
      case ($urandom_range(19))
        0:       w_raw = rilbp_pkg::CFG_DATA_BITS'($urandom_range(2));
        1:       w_raw = {4'($urandom_range(1, 15)), 8'($urandom_range(3, 16))};
        default: w_raw = {4'($urandom_range(15)), 8'($urandom_range(3, 10))};
      endcase
      if ($urandom_range(7) == 0) h_raw = rilbp_pkg::CFG_DATA_BITS'($urandom_range(2));
      else                        h_raw = rilbp_pkg::CFG_DATA_BITS'($urandom_range(3, 6));
      write_reg(rilbp_pkg::REG_IMAGE_WIDTH, w_raw);
      write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, h_raw);
      repeat ($urandom_range(1, 2)) send_frame();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= rilbp_pkg::REG_IMAGE_WIDTH;
    cfg_data      <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.pixel  <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fail_count  = 0;
    pixels_sent = 0;
    width_reg   = rilbp_pkg::IMAGE_WIDTH_RST;
    height_reg  = rilbp_pkg::IMAGE_HEIGHT_RST;
    row_idx     = 0;
    col_idx     = 0;
    foreach (line_rows[i, j]) line_rows[i][j] = '0;
    foreach (win_cols[i, j]) win_cols[i][j] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_code_patterns();
    test_register_extremes();
    test_mid_row_resize();
    test_random_frames(0, 0, 90);
    test_random_frames(76, 0, 90);
    test_random_frames(0, 76, 90);
    test_random_frames(18, 18, 90);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_rotation_invariant_lbp_3x3 OK");
    end else begin
      $display("tb_rotation_invariant_lbp_3x3 NOT OK");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("tb_rotation_invariant_lbp_3x3 NOT OK");
    $finish;
  end

endmodule
